// ===== rtl/core/nonmax_suppression_3x3_unit_macros.svh =====
// Assertion macros for the 3x3 non-maximum suppression block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef NONMAX_SUPPRESSION_3X3_UNIT_MACROS_SVH
`define NONMAX_SUPPRESSION_3X3_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on the rising clock edge.
`define NMS3_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define NMS3_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define NMS3_ASSERT_IMP(label, clk, rst, ante, cons)
`define NMS3_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/nms3_pkg.sv =====
// Shared constants and types for the 3x3 non-maximum suppression block.
// No dependencies.
package nms3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIXEL_BITS = 8;

  localparam int COL_BITS   = 11;
  localparam int ROW_BITS   = 12;
  localparam int WIDTH_BITS = 12;
  localparam int HEIGHT_BITS = 13;
  localparam int CFG_BITS   = 13;
  localparam int CFG_IDX_BITS = 2;
  localparam int OUT_DATA_BITS = 32;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN   = WIDTH_BITS'(3);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX   = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN  = HEIGHT_BITS'(3);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX  = HEIGHT_BITS'(MAX_HEIGHT);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);
  localparam logic [PIXEL_BITS-1:0]  PIXEL_FULL   = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_KEEP_VALUES  = 2'd2
  } cfg_index_t;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

endpackage

// ===== rtl/core/nms3_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module nms3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/nonmax_suppression_3x3_unit.sv =====
// Top level of the 3x3 non-maximum suppression block: counters, line buffers, window.
// Depends on nms3_pkg, nms3_ram and nonmax_suppression_3x3_unit_macros.svh.
//
//   channel  | handshake        | payload
//   ---------+------------------+-----------------------------------------------
//   s_       | s_tvalid/tready  | tdata: pixel; tuser: frame_start
//   m_       | m_tvalid/tready  | tdata: out_value, out_row, out_col; tlast
//   cfg_     | cfg_we           | cfg_index, cfg_data
//
// One pixel per cycle unless stalled; a result passes stage 1, then the output register.
// Line buffer reads are registered, which sets the two-stage depth.
// The whole pipe stalls only while a result sits in the output register untaken.
// Reset (rst, synchronous) clears counters, window and valid flags; line buffers
// hold no reset and need no clearing pass.
module nonmax_suppression_3x3_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // [7:0] pixel
  input  logic                                 s_tuser,   // [0] frame_start
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [nms3_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // [7:0] out_value,
                                                          // [19:8] out_row,
                                                          // [30:20] out_col, [31] zero
  output logic                                 m_tlast,   // frame_last
  input  logic                                 cfg_we,
  input  logic [nms3_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [nms3_pkg::CFG_BITS-1:0]        cfg_data
);

  // configuration
  logic [nms3_pkg::WIDTH_BITS-1:0]  image_width;
  logic [nms3_pkg::HEIGHT_BITS-1:0] image_height;
  logic                             keep_values;

  // position of the next pixel
  logic [nms3_pkg::COL_BITS-1:0] col_count;
  logic [nms3_pkg::ROW_BITS-1:0] row_count;

  // stage 1: pixel waiting for its line buffer data
  logic                          s1_valid;
  nms3_pkg::pixel_t              s1_px;
  logic [nms3_pkg::COL_BITS-1:0] s1_col;
  logic                          s1_emit;
  logic                          s1_last;
  logic [nms3_pkg::ROW_BITS-1:0] s1_out_row;
  logic [nms3_pkg::COL_BITS-1:0] s1_out_col;
  logic                          byp_hit;
  nms3_pkg::pixel_t              byp_upper;
  nms3_pkg::pixel_t              byp_middle;

  // window columns c-2 (win0..2) and c-1 (win3..5), top to bottom
  nms3_pkg::pixel_t win0, win1, win2, win3, win4, win5;

  // output register
  logic                          o_valid;
  nms3_pkg::pixel_t              o_value;
  logic [nms3_pkg::ROW_BITS-1:0] o_row;
  logic [nms3_pkg::COL_BITS-1:0] o_col;
  logic                          o_last;

  logic [nms3_pkg::WIDTH_BITS-1:0]  w_lim;
  logic [nms3_pkg::HEIGHT_BITS-1:0] h_lim;
  logic                             en;
  logic                             accept;
  logic [nms3_pkg::COL_BITS-1:0]    col_cur;
  logic [nms3_pkg::ROW_BITS-1:0]    row_cur;
  logic [nms3_pkg::WIDTH_BITS-1:0]  col_ext;
  logic [nms3_pkg::HEIGHT_BITS-1:0] row_ext;
  logic                             in_range;
  logic                             at_last;
  logic [nms3_pkg::COL_BITS-1:0]    col_count_next;
  logic [nms3_pkg::ROW_BITS-1:0]    row_count_next;
  nms3_pkg::pixel_t                 upper_q, middle_q;
  nms3_pkg::pixel_t                 top_val, mid_val;
  logic                             is_max;
  logic                             wr_en;
  nms3_pkg::pixel_t                 res_value;

  // clamp the frame size
  always_comb begin
    if (image_width < nms3_pkg::WIDTH_MIN) begin
      w_lim = nms3_pkg::WIDTH_MIN;
    end else if (image_width > nms3_pkg::WIDTH_MAX) begin
      w_lim = nms3_pkg::WIDTH_MAX;
    end else begin
      w_lim = image_width;
    end
    if (image_height < nms3_pkg::HEIGHT_MIN) begin
      h_lim = nms3_pkg::HEIGHT_MIN;
    end else if (image_height > nms3_pkg::HEIGHT_MAX) begin
      h_lim = nms3_pkg::HEIGHT_MAX;
    end else begin
      h_lim = image_height;
    end
  end

  assign en       = !o_valid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;
  assign wr_en    = s1_valid && en;

  // stage 0: position, emit decision and counter advance
  always_comb begin
    col_cur  = s_tuser ? '0 : col_count;
    row_cur  = s_tuser ? '0 : row_count;
    col_ext  = {1'b0, col_cur};
    row_ext  = {1'b0, row_cur};
    in_range = (col_ext >= nms3_pkg::WIDTH_BITS'(2)) && (col_ext < w_lim) &&
               (row_ext >= nms3_pkg::HEIGHT_BITS'(2)) && (row_ext < h_lim);
    at_last  = (row_ext == h_lim - nms3_pkg::HEIGHT_BITS'(1)) &&
               (col_ext == w_lim - nms3_pkg::WIDTH_BITS'(1));
    if (col_ext + nms3_pkg::WIDTH_BITS'(1) >= w_lim) begin
      col_count_next = '0;
      if (row_ext + nms3_pkg::HEIGHT_BITS'(1) >= h_lim) begin
        row_count_next = '0;
      end else begin
        row_count_next = row_cur + nms3_pkg::ROW_BITS'(1);
      end
    end else begin
      col_count_next = col_cur + nms3_pkg::COL_BITS'(1);
      row_count_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= nms3_pkg::WIDTH_RESET;
      image_height <= nms3_pkg::HEIGHT_RESET;
      keep_values  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        nms3_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[nms3_pkg::WIDTH_BITS-1:0];
        nms3_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        nms3_pkg::CFG_KEEP_VALUES:  keep_values  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // line buffers: read at acceptance, written back from stage 1 when the pipe advances
  nms3_ram #(
    .WIDTH(nms3_pkg::PIXEL_BITS),
    .DEPTH(nms3_pkg::MAX_WIDTH)
  ) u_line_upper (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_col),
    .wdata (mid_val),
    .re    (accept),
    .raddr (col_cur),
    .rdata (upper_q)
  );

  nms3_ram #(
    .WIDTH(nms3_pkg::PIXEL_BITS),
    .DEPTH(nms3_pkg::MAX_WIDTH)
  ) u_line_middle (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_col),
    .wdata (s1_px),
    .re    (accept),
    .raddr (col_cur),
    .rdata (middle_q)
  );

  // stage 1 registers; forward the pending write when the next read hits its column
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px      <= s_tdata;
      s1_col     <= col_cur;
      s1_emit    <= in_range;
      s1_last    <= at_last;
      s1_out_row <= row_cur - nms3_pkg::ROW_BITS'(1);
      s1_out_col <= col_cur - nms3_pkg::COL_BITS'(1);
      byp_hit    <= s1_valid && (s1_col == col_cur);
      byp_upper  <= mid_val;
      byp_middle <= s1_px;
    end
  end

  assign top_val = byp_hit ? byp_upper  : upper_q;
  assign mid_val = byp_hit ? byp_middle : middle_q;

  // stage 2: compare the centre against its eight neighbours
  always_comb begin
    is_max = (win4 > win0) && (win4 > win1) && (win4 > win2) && (win4 > win3) &&
             (win4 > win5) && (win4 > top_val) && (win4 > mid_val) && (win4 > s1_px);
    if (!is_max) begin
      res_value = '0;
    end else if (keep_values) begin
      res_value = win4;
    end else begin
      res_value = nms3_pkg::PIXEL_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win0 <= '0;
      win1 <= '0;
      win2 <= '0;
      win3 <= '0;
      win4 <= '0;
      win5 <= '0;
    end else if (wr_en) begin
      win0 <= win3;
      win1 <= win4;
      win2 <= win5;
      win3 <= top_val;
      win4 <= mid_val;
      win5 <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && s1_emit) begin
      o_value <= res_value;
      o_row   <= s1_out_row;
      o_col   <= s1_out_col;
      o_last  <= s1_last;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {1'b0, o_col, o_row, o_value};
  assign m_tlast  = o_last;

  // checks
  `include "nonmax_suppression_3x3_unit_macros.svh"

  `NMS3_ASSERT_IMP(a_result_from_stage1, clk, rst, $rose(o_valid), $past(s1_valid && s1_emit))
  `NMS3_ASSERT_IMP(a_result_interior, clk, rst, o_valid, (o_row != '0) && (o_col != '0))
  `NMS3_ASSERT_IMP(a_last_on_bottom_row, clk, rst, o_valid && o_last,
                   nms3_pkg::HEIGHT_BITS'(o_row) + nms3_pkg::HEIGHT_BITS'(2) == h_lim)
  `NMS3_ASSERT_NEXT(a_stall_holds_stage1, clk, rst, s1_valid && !en, s1_valid && $stable(s1_col))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for nonmax_suppression_3x3_unit: raster frames of random pixels
// in, suppressed window centres out, checked against an in-bench model of the 3x3 window.
// Depends on nms3_pkg and the block's RTL only.
module testbench;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int RANDOM_ITEMS  = 600;
  localparam int WIDE_ITEMS    = 64;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic             fs;
    nms3_pkg::pixel_t pix;
  } pixel_item_t;

  typedef struct packed {
    logic                          last;
    logic [nms3_pkg::COL_BITS-1:0] col;
    logic [nms3_pkg::ROW_BITS-1:0] row;
    nms3_pkg::pixel_t              value;
  } nms_result_t;

  typedef enum int {PIX_FULL_RANGE, PIX_PLATEAU, PIX_SPARSE_PEAKS} pixel_mix_t;

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               s_tvalid  = 1'b0;
  logic                               s_tready;
  logic [7:0]                         s_tdata   = '0;
  logic                               s_tuser   = 1'b0;
  logic                               m_tvalid;
  logic                               m_tready  = 1'b0;
  logic [nms3_pkg::OUT_DATA_BITS-1:0] m_tdata;
  logic                               m_tlast;
  logic                               cfg_we    = 1'b0;
  logic [nms3_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [nms3_pkg::CFG_BITS-1:0]      cfg_data  = '0;

  // Block state as the bench sees it
  logic [nms3_pkg::WIDTH_BITS-1:0]  cfg_width  = nms3_pkg::WIDTH_RESET;
  logic [nms3_pkg::HEIGHT_BITS-1:0] cfg_height = nms3_pkg::HEIGHT_RESET;
  logic                             cfg_keep   = 1'b0;
  nms3_pkg::pixel_t                 older_line [nms3_pkg::MAX_WIDTH];
  nms3_pkg::pixel_t                 newer_line [nms3_pkg::MAX_WIDTH];
  // [0..2] two columns back (top, middle, bottom), [3..5] one column back
  nms3_pkg::pixel_t                 win_px [6];
  int unsigned                      pos_col = 0;
  int unsigned                      pos_row = 0;

  pixel_item_t pixel_q [$];
  nms_result_t suppressed_q [$];

  bit          idle_on      = 1'b0;
  int          src_gap      = 0;
  int          sink_gap     = 0;
  int          error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned random_items = 0;

  nonmax_suppression_3x3_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic nms3_pkg::pixel_t draw_pixel(input pixel_mix_t mix);
    case (mix)
      PIX_FULL_RANGE: return nms3_pkg::pixel_t'($urandom_range(0, 255));
      PIX_PLATEAU:    return nms3_pkg::pixel_t'($urandom_range(0, 3));
      default: begin
        if ($urandom_range(0, 15) == 0) return nms3_pkg::pixel_t'($urandom_range(200, 255));
        return nms3_pkg::pixel_t'($urandom_range(0, 60));
      end
    endcase
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < 10) $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  // Advance the window by one pixel and queue the result it completes, if any.
  task automatic compute_suppression(input pixel_item_t it);
    int unsigned      w, h, col, row;
    nms3_pkg::pixel_t top, mid, c;
    logic             peak;
    nms_result_t      r;
    w = clamp_size(cfg_width, 3, nms3_pkg::MAX_WIDTH);
    h = clamp_size(cfg_height, 3, nms3_pkg::MAX_HEIGHT);
    if (it.fs) begin
      pos_col = 0;
      pos_row = 0;
    end
    col = pos_col;
    row = pos_row;
    top = '0;
    mid = '0;
    if (col < nms3_pkg::MAX_WIDTH) begin
      top = older_line[col];
      mid = newer_line[col];
      older_line[col] = mid;
      newer_line[col] = it.pix;
    end
    if (col >= 2 && col < w && row >= 2 && row < h) begin
      c = win_px[4];
      // plateaus never count: every neighbour must be strictly lower
      peak = c > win_px[0] && c > win_px[1] && c > win_px[2] && c > win_px[3] &&
             c > win_px[5] && c > top && c > mid && c > it.pix;
      r.value = !peak ? nms3_pkg::pixel_t'(0) : (cfg_keep ? c : nms3_pkg::PIXEL_FULL);
      r.row   = nms3_pkg::ROW_BITS'(row - 1);
      r.col   = nms3_pkg::COL_BITS'(col - 1);
      r.last  = (row == h - 1) && (col == w - 1);
      suppressed_q.push_back(r);
    end
    win_px[0] = win_px[3];
    win_px[1] = win_px[4];
    win_px[2] = win_px[5];
    win_px[3] = top;
    win_px[4] = mid;
    win_px[5] = it.pix;
    if (col + 1 >= w) begin
      pos_col = 0;
      pos_row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      pos_col = col + 1;
    end
  endtask

  // Pixel driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap  <= 0;
    end else begin
      if (s_tvalid && s_tready) compute_suppression(pixel_q.pop_front());
      // hold an offered item until it is taken
      if (!s_tvalid || s_tready) begin
        if (idle_on && src_gap != 0) begin
          src_gap  <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          src_gap  <= $urandom_range(0, 18);
          s_tvalid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pixel_q[0].pix;
          s_tuser  <= pixel_q[0].fs;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : sink
    nms_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (suppressed_q.size() == 0) begin
          flag_error($sformatf("result with nothing expected: data %h last %b",
                               m_tdata, m_tlast));
        end else begin
          want = suppressed_q.pop_front();
          if (m_tdata[7:0] !== want.value || m_tdata[19:8] !== want.row ||
              m_tdata[30:20] !== want.col || m_tdata[31] !== 1'b0 ||
              m_tlast !== want.last)
            flag_error($sformatf(
              "exp val %0d row %0d col %0d last %b, got val %0d row %0d col %0d last %b pad %b",
              want.value, want.row, want.col, want.last,
              m_tdata[7:0], m_tdata[19:8], m_tdata[30:20], m_tlast, m_tdata[31]));
        end
      end
      if (idle_on && sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        sink_gap <= $urandom_range(0, 18);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(input nms3_pkg::cfg_index_t idx,
                           input logic [nms3_pkg::CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      nms3_pkg::CFG_IMAGE_WIDTH:  cfg_width  = val[nms3_pkg::WIDTH_BITS-1:0];
      nms3_pkg::CFG_IMAGE_HEIGHT: cfg_height = val[nms3_pkg::HEIGHT_BITS-1:0];
      default:                    cfg_keep   = val[0];
    endcase
  endtask

  task automatic configure(input logic [nms3_pkg::CFG_BITS-1:0] w,
                           input logic [nms3_pkg::CFG_BITS-1:0] h,
                           input logic [nms3_pkg::CFG_BITS-1:0] k, input logic [2:0] which);
    if (which[0]) write_reg(nms3_pkg::CFG_IMAGE_WIDTH, w);
    if (which[1]) write_reg(nms3_pkg::CFG_IMAGE_HEIGHT, h);
    if (which[2]) write_reg(nms3_pkg::CFG_KEEP_VALUES, k);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_frame3(input logic [71:0] pix, input bit fs);
    pixel_item_t it;
    for (int i = 0; i < 9; i++) begin
      it.pix = pix[8*i +: 8];
      it.fs  = fs && i == 0;
      pixel_q.push_back(it);
    end
  endtask

  task automatic push_pixels(input int unsigned n, input pixel_mix_t mix, input bit fs_first,
                             input bit noisy);
    pixel_item_t it;
    for (int unsigned i = 0; i < n; i++) begin
      it.pix = draw_pixel(mix);
      // stray frame starts cut frames short
      it.fs  = (i == 0 && fs_first) || (noisy && $urandom_range(0, 199) == 0);
      pixel_q.push_back(it);
    end
  endtask

  // Wait until every item is taken and every result has come, then let the pipe settle.
  task automatic drain();
    while (pixel_q.size() != 0 || s_tvalid || suppressed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned w, h, n;
    logic [2:0]  which;
    bit          wide;
    foreach (older_line[i]) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    foreach (win_px[i]) win_px[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Smallest image: each 3x3 frame gives one result, the last of its frame.
    configure(13'd3, 13'd3, 13'd1, 3'b111);
    // strict peak at full scale, own value kept
    push_frame3({8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd254, 8'd254, 8'd254, 8'd254},
                1'b1);
    // no frame start: counters wrap by themselves; an equal neighbour blocks the peak
    push_frame3({8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0);
    drain();
    configure(13'd0, 13'd0, 13'd0, 3'b100);
    push_frame3({8'd1, 8'd127, 8'd0, 8'd127, 8'd128, 8'd16, 8'd127, 8'd0, 8'd127}, 1'b1);
    drain();

    // Small random images; phases may end mid-frame and change the size there.
    while (random_items < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      case ($urandom_range(0, 9))
        0:       h = $urandom_range(0, 2);
        1:       h = $urandom_range(4097, 8191);
        default: h = $urandom_range(3, 8);
      endcase
      which = 3'($urandom_range(0, 7));
      // a wider row needs a fresh frame so that no unwritten line entry is read
      wide = which[0] && clamp_size(w, 3, nms3_pkg::MAX_WIDTH) >
                         clamp_size(cfg_width, 3, nms3_pkg::MAX_WIDTH);
      configure({1'($urandom_range(0, 1)), 12'(w)}, 13'(h),
                {12'($urandom), 1'($urandom_range(0, 1))}, which);
      idle_on = ($urandom_range(0, 3) != 0);
      w = clamp_size(cfg_width, 3, nms3_pkg::MAX_WIDTH);
      h = clamp_size(cfg_height, 3, nms3_pkg::MAX_HEIGHT);
      if (h > 8)
        n = w * $urandom_range(3, 9);
      else
        n = $urandom_range(1, 2) * w * h +
            ($urandom_range(0, 1) ? $urandom_range(1, w * h - 1) : 0);
      push_pixels(n, pixel_mix_t'($urandom_range(0, 2)), wide || $urandom_range(0, 1), 1'b1);
      random_items += n;
      drain();
    end

    // Widest row, clamped or exact: a short stretch of the first row
    configure(13'($urandom_range(0, 1) ? nms3_pkg::MAX_WIDTH : $urandom_range(2049, 4095)),
              13'($urandom_range(0, 3)), 13'($urandom_range(0, 1)), 3'b111);
    idle_on = 1'b1;
    push_pixels(WIDE_ITEMS, PIX_FULL_RANGE, 1'b1, 1'b0);
    drain();

    // Closing frames at full rate on both sides
    idle_on = 1'b0;
    w = $urandom_range(4, 8);
    h = $urandom_range(3, 5);
    configure(13'(w), 13'(h), 13'($urandom_range(0, 1)), 3'b111);
    push_pixels(2 * w * h, PIX_SPARSE_PEAKS, 1'b1, 1'b0);
    drain();

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
